FILE: rtl/core/rcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rcc_pkg;

    // default sizes, handed to the top level parameters
    localparam int DEF_MAX_PIXELS   = 65536;
    localparam int DEF_SAMPLE_WIDTH = 16;
    localparam int DEF_MAX_CHANNELS = 64;

    // configuration register widths and reset values
    localparam int CHAN_COUNT_W = 7;
    localparam int PIX_COUNT_W  = 17;
    localparam int CFG_DATA_W   = 17;
    localparam int CFG_INDEX_W  = 1;

    localparam logic [CHAN_COUNT_W-1:0] CHAN_COUNT_RST = 7'd1;
    localparam logic [PIX_COUNT_W-1:0]  PIX_COUNT_RST  = 17'd65536;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_CHANNEL_COUNT = 1'b0,
        CFG_PIXEL_COUNT   = 1'b1
    } t_cfg_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQUARE,
        S_ACCUM,
        S_ROOT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic square;
        logic accum;
        logic root_start;
        logic out_load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic last_chan;
        logic root_done;
    } t_status;

endpackage

`default_nettype wire

FILE: rtl/core/rcc_sqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module rcc_sqrt
    import rcc_pkg::*;
#(
    parameter int OP_W = 38,
    localparam int ROOT_W = (OP_W + 1) / 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [OP_W-1:0]   i_operand,
    output logic                   o_busy,
    output logic [ROOT_W-1:0]      o_root
);

    localparam int XW    = 2 * ROOT_W;
    localparam int CNT_W = $clog2(ROOT_W + 1);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [XW-1:0]     r_x;
    logic [ROOT_W+1:0] r_rem;
    logic [ROOT_W-1:0] r_root;

    logic [ROOT_W+1:0] rem_sh;
    logic [ROOT_W+1:0] trial;
    logic [ROOT_W+1:0] diff;
    logic              fits;

    // one result bit per cycle, two operand bits shifted in
    always_comb begin
        rem_sh = {r_rem[ROOT_W-1:0], r_x[XW-1 -: 2]};
        trial  = {r_root, 2'b01};
        fits   = (rem_sh >= trial);
        diff   = rem_sh - trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ROOT_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= XW'(i_operand);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_x    <= {r_x[XW-3:0], 2'b00};
            r_rem  <= fits ? diff : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("root started while busy");

    a_count_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy == (r_cnt != '0))
        else $error("root counter and busy disagree");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(ROOT_W))
        else $error("root counter beyond the result width");

endmodule

`default_nettype wire

FILE: rtl/core/rcc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module rcc_datapath
    import rcc_pkg::*;
#(
    parameter int MAX_PIXELS   = DEF_MAX_PIXELS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    localparam int SUM_W = 2 * SAMPLE_WIDTH + $clog2(MAX_CHANNELS),
    localparam int MAG_W = (SUM_W + 1) / 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [SAMPLE_WIDTH-1:0]  i_sample_real,
    input  wire logic [SAMPLE_WIDTH-1:0]  i_sample_imag,
    input  wire t_cmd                     i_cmd,
    output t_status                       o_status,
    output logic [MAG_W-1:0]              o_magnitude,
    output logic                          o_last_pixel
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SQ_W = 2 * SAMPLE_WIDTH;

    logic [CHAN_COUNT_W-1:0] r_chan_count;
    logic [PIX_COUNT_W-1:0]  r_pix_count;
    logic [AW-1:0]           r_pix_pos;
    logic [CW-1:0]           r_chan_pos;

    logic [SUM_W-1:0]        mem [MAX_PIXELS];
    logic [SUM_W-1:0]        r_rd_data;
    logic [SQ_W-1:0]         r_sq_re;
    logic [SQ_W-1:0]         r_sq_im;
    logic [SQ_W-1:0]         r_sq_sum;
    logic [AW-1:0]           r_item_pix;
    logic                    r_item_first;
    logic                    r_item_last;
    logic                    r_item_final;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_last_pixel;

    logic [31:0]             pix_lim;
    logic [31:0]             chan_lim;
    logic [AW-1:0]           pix_last;
    logic [CW-1:0]           chan_last;
    logic signed [SQ_W-1:0]  sq_re;
    logic signed [SQ_W-1:0]  sq_im;
    logic [SUM_W-1:0]        acc_sum;
    logic                    root_busy;
    logic [MAG_W-1:0]        root;

    // zero counts act as one, large counts saturate at MAX_PIXELS and MAX_CHANNELS
    always_comb begin
        if (r_pix_count == '0) begin
            pix_lim = 32'd1;
        end else if (32'(r_pix_count) > 32'(MAX_PIXELS)) begin
            pix_lim = 32'(MAX_PIXELS);
        end else begin
            pix_lim = 32'(r_pix_count);
        end
        if (r_chan_count == '0) begin
            chan_lim = 32'd1;
        end else if (32'(r_chan_count) > 32'(MAX_CHANNELS)) begin
            chan_lim = 32'(MAX_CHANNELS);
        end else begin
            chan_lim = 32'(r_chan_count);
        end
        pix_last  = AW'(pix_lim - 32'd1);
        chan_last = CW'(chan_lim - 32'd1);
    end

    always_comb begin
        sq_re   = $signed(i_sample_real) * $signed(i_sample_real);
        sq_im   = $signed(i_sample_imag) * $signed(i_sample_imag);
        acc_sum = (r_item_first ? '0 : r_rd_data) + SUM_W'(r_sq_sum);
    end

    // configuration and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan_count <= CHAN_COUNT_RST;
            r_pix_count  <= PIX_COUNT_RST;
            r_pix_pos    <= '0;
            r_chan_pos   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_CHANNEL_COUNT: r_chan_count <= i_cfg_data[CHAN_COUNT_W-1:0];
                CFG_PIXEL_COUNT:   r_pix_count  <= i_cfg_data[PIX_COUNT_W-1:0];
            endcase
            r_pix_pos  <= '0;
            r_chan_pos <= '0;
        end else if (i_cmd.accept) begin
            if (r_pix_pos == pix_last) begin
                r_pix_pos  <= '0;
                r_chan_pos <= (r_chan_pos == chan_last) ? '0 : r_chan_pos + 1'b1;
            end else begin
                r_pix_pos <= r_pix_pos + 1'b1;
            end
        end
    end

    // sum store
    always_ff @(posedge i_clk) begin
        if (i_cmd.accum) begin
            mem[r_item_pix] <= acc_sum;
        end
        if (i_cmd.accept) begin
            r_rd_data <= mem[r_pix_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sq_re      <= $unsigned(sq_re);
            r_sq_im      <= $unsigned(sq_im);
            r_item_pix   <= r_pix_pos;
            r_item_first <= (r_chan_pos == '0);
            r_item_last  <= (r_chan_pos == chan_last);
            r_item_final <= (r_pix_pos == pix_last);
        end
        if (i_cmd.square) begin
            r_sq_sum <= r_sq_re + r_sq_im;
        end
        if (i_cmd.out_load) begin
            r_mag        <= root;
            r_last_pixel <= r_item_final;
        end
    end

    rcc_sqrt #(
        .OP_W (SUM_W)
    ) u_sqrt (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_cmd.root_start),
        .i_operand (acc_sum),
        .o_busy    (root_busy),
        .o_root    (root)
    );

    assign o_status.last_chan = r_item_last;
    assign o_status.root_done = !root_busy;
    assign o_magnitude        = r_mag;
    assign o_last_pixel       = r_last_pixel;

endmodule

`default_nettype wire

FILE: rtl/core/rcc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module rcc_ctrl
    import rcc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SQUARE;
                end
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ACCUM;
            end
            S_ACCUM: begin
                o_cmd.accum = 1'b1;
                if (i_status.last_chan) begin
                    o_cmd.root_start = 1'b1;
                    n_state          = S_ROOT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ROOT: begin
                // wait for the root, then for room in the output register
                if (i_status.root_done && (!r_out_valid || i_out_ready)) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is at work");

    a_root_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.root_start |-> i_status.last_chan)
        else $error("root started on an item that is not the last channel");

    a_load_after_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (i_status.root_done && $past(r_state) == S_ROOT))
        else $error("result loaded before root finished");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.out_load && r_out_valid) |-> i_out_ready)
        else $error("waiting result overwritten");

endmodule

`default_nettype wire

FILE: rtl/core/rss_coil_combine.sv
`timescale 1ns / 1ps
`default_nettype none

// root-sum-of-squares coil combine
// input channel (i_in_valid / o_in_ready) carries one complex coil sample per
// transfer, channel-major: every pixel of coil 0, then every pixel of coil 1 ...
// output channel (o_out_valid / i_out_ready) carries one magnitude per pixel,
// only on the last coil; o_last_pixel marks the final pixel of the image
// configuration: i_cfg_wr_en writes channel_count (index 0) or pixel_count
// (index 1); any write restarts the image at pixel 0, coil 0
// timing: one sample at a time, stepped through accept, square and accumulate into
// the sum store on all but the last coil; on the last coil the bit-serial root then
// produces one result bit per cycle, 19 result bits at default sizes, and the
// result is loaded into the output register before the block takes the next
// sample
// a finished result waits in the output register while the next samples are
// taken; if the receiver stalls, a further result holds the block at the root
// stage until the register empties
// reset: positions return to zero, channel_count to 1, pixel_count to 65536;
// the sum store is not cleared, coil 0 ignores the stored value and writes every pixel

module rss_coil_combine
    import rcc_pkg::*;
#(
    parameter int MAX_PIXELS   = DEF_MAX_PIXELS,
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
    localparam int SUM_W = 2 * SAMPLE_WIDTH + $clog2(MAX_CHANNELS),
    localparam int MAG_W = (SUM_W + 1) / 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // configuration write port
    input  wire logic                     i_cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    i_cfg_data,
    // sample input
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [SAMPLE_WIDTH-1:0]  i_sample_real,
    input  wire logic [SAMPLE_WIDTH-1:0]  i_sample_imag,
    // magnitude output
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [MAG_W-1:0]              o_magnitude,
    output logic                          o_last_pixel
);

    t_cmd    cmd;
    t_status status;

    // sequencer: one state per step of a sample
    rcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // squares, sum store, root unit and output register
    rcc_datapath #(
        .MAX_PIXELS   (MAX_PIXELS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_sample_real (i_sample_real),
        .i_sample_imag (i_sample_imag),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_magnitude   (o_magnitude),
        .o_last_pixel  (o_last_pixel)
    );

endmodule

`default_nettype wire
